### design/a32dec_pkg.sv
package a32dec_pkg;

   // Instruction classes
   localparam logic [4:0] CLS_BX       = 5'd0;
   localparam logic [4:0] CLS_SWP      = 5'd1;
   localparam logic [4:0] CLS_MUL      = 5'd2;
   localparam logic [4:0] CLS_MULL     = 5'd3;
   localparam logic [4:0] CLS_CDP      = 5'd4;
   localparam logic [4:0] CLS_MRC_MCR  = 5'd5;
   localparam logic [4:0] CLS_SWI      = 5'd6;
   localparam logic [4:0] CLS_HALF     = 5'd7;
   localparam logic [4:0] CLS_BLOCK    = 5'd8;
   localparam logic [4:0] CLS_BRANCH   = 5'd9;
   localparam logic [4:0] CLS_LDC_STC  = 5'd10;
   localparam logic [4:0] CLS_DATAPROC = 5'd11;
   localparam logic [4:0] CLS_LDR_STR  = 5'd12;
   localparam logic [4:0] CLS_NOP      = 5'd13;
   localparam logic [4:0] CLS_MRS      = 5'd14;
   localparam logic [4:0] CLS_MSR      = 5'd15;
   localparam logic [4:0] CLS_MOVW     = 5'd16;

   // Shift kinds
   localparam logic [3:0] SHK_LSR_IMM = 4'd2;
   localparam logic [3:0] SHK_ASR_IMM = 4'd4;
   localparam logic [3:0] SHK_ROR_IMM = 4'd6;
   localparam logic [3:0] SHK_RRX     = 4'd8;

   // Mask / match pairs of the class chain
   localparam logic [31:0] BX_MASK    = 32'h0fff_ffd0;
   localparam logic [31:0] BX_MATCH   = 32'h012f_ff10;
   localparam logic [31:0] SWP_MASK   = 32'h0fb0_0ff0;
   localparam logic [31:0] SWP_MATCH  = 32'h0100_0090;
   localparam logic [31:0] MUL_MASK   = 32'h0fc0_00f0;
   localparam logic [31:0] MUL_MATCH  = 32'h0000_0090;
   localparam logic [31:0] MULL_MASK  = 32'h0f80_00f0;
   localparam logic [31:0] MULL_MATCH = 32'h0080_0090;
   localparam logic [31:0] CP_MASK    = 32'h0f00_0010;
   localparam logic [31:0] CDP_MATCH  = 32'h0e00_0000;
   localparam logic [31:0] MRC_MATCH  = 32'h0e00_0010;
   localparam logic [31:0] SWI_MASK   = 32'h0f00_0000;
   localparam logic [31:0] SWI_MATCH  = 32'h0f00_0000;
   localparam logic [31:0] HALF_MASK  = 32'h0e00_0090;
   localparam logic [31:0] HALF_MATCH = 32'h0000_0090;
   localparam logic [31:0] TOP3_MASK  = 32'h0e00_0000;
   localparam logic [31:0] BLK_MATCH  = 32'h0800_0000;
   localparam logic [31:0] BR_MATCH   = 32'h0a00_0000;
   localparam logic [31:0] LDC_MATCH  = 32'h0c00_0000;
   localparam logic [31:0] DP_MASK    = 32'h0c00_0000;
   localparam logic [31:0] DP_MATCH   = 32'h0000_0000;
   localparam logic [31:0] NOP_WORD   = 32'he1a0_0000;
   localparam logic [31:0] MRS_MASK   = 32'h0fbf_0fff;
   localparam logic [31:0] MRS_MATCH  = 32'h010f_0000;
   localparam logic [31:0] MSR_MASK   = 32'h0db0_f000;
   localparam logic [31:0] MSR_MATCH  = 32'h0120_f000;
   localparam logic [31:0] MOVW_MASK  = 32'h0fb0_0000;
   localparam logic [31:0] MOVW_MATCH = 32'h0300_0000;

   // Valid msr field masks
   localparam logic [3:0] MSR_FM_CF = 4'd9;
   localparam logic [3:0] MSR_FM_F  = 4'd8;
   localparam logic [3:0] MSR_FM_C  = 4'd1;

   typedef struct packed {
      logic        recognized;
      logic [4:0]  insn_class;
      logic [3:0]  cond_code;
      logic [3:0]  opcode;
      logic [3:0]  reg_dest;
      logic [3:0]  reg_base;
      logic [3:0]  reg_second;
      logic [3:0]  reg_shift;
      logic [31:0] operand_value;
      logic [5:0]  flag_bits;
      logic [3:0]  shift_kind;
      logic [5:0]  shift_amount;
   } dec_result_type;

endpackage

### design/arm32_instruction_decoder_unit.sv
// Channel  Dir  Bits of tdata / tuser           Carries
// req      in   tdata 64                        instruction word and its fetch address
// rsp      out  tdata 72, tuser 6               decoded fields; tuser holds status and class
//
// One beat in, one beat out. A word passes through the input register and then
// the result register, and the pipe takes a new beat every cycle while the
// result side keeps up.
// The decode itself is one pass of mask/match logic between those registers.
// reset (synchronous) empties both registers; payloads are not cleared.
// A stall on rsp holds the result register and backs up into the input
// register; req_tready drops only when both stages are full and stalled.
module arm32_instruction_decoder_unit
   import a32dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] insn_word, [63:32] fetch_address

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] cond_code, [7:4] opcode, [11:8] reg_dest,
                                    // [15:12] reg_base, [19:16] reg_second,
                                    // [23:20] reg_shift, [55:24] operand_value,
                                    // [61:56] flag_bits, [65:62] shift_kind,
                                    // [71:66] shift_amount
   output logic [5:0]  rsp_tuser    // [0] recognized, [5:1] insn_class
);

   // Input stage
   logic           in_valid_ff, in_valid_in;
   logic [31:0]    in_word_ff;
   logic [31:0]    in_addr_ff;

   // Result stage
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_res_ff;
   dec_result_type dec_res;

   logic req_beat;
   logic advance;

   // Input stage moves on when the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_word_ff <= req_tdata[31:0];
         in_addr_ff <= req_tdata[63:32];
      end
   end

   a32dec_decode u_decode (
      .insn_word     (in_word_ff),
      .fetch_address (in_addr_ff),
      .result        (dec_res)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_res_ff.insn_class, out_res_ff.recognized};
   assign rsp_tdata  = {out_res_ff.shift_amount,
                        out_res_ff.shift_kind,
                        out_res_ff.flag_bits,
                        out_res_ff.operand_value,
                        out_res_ff.reg_shift,
                        out_res_ff.reg_second,
                        out_res_ff.reg_base,
                        out_res_ff.reg_dest,
                        out_res_ff.opcode,
                        out_res_ff.cond_code};

endmodule

### design/a32dec_decode.sv
module a32dec_decode
   import a32dec_pkg::*;
(
   input  logic [31:0]    insn_word,
   input  logic [31:0]    fetch_address,
   output dec_result_type result
);

   logic [31:0] rot_imm;
   logic [63:0] rot_pair;
   logic [4:0]  rot_amt;
   logic [31:0] br_offset;
   logic [3:0]  sh_kind;
   logic [5:0]  sh_amt;
   logic [2:0]  sh_type;
   logic [4:0]  sh_field;

   assign rot_amt  = {insn_word[11:8], 1'b0};
   assign rot_pair = {24'd0, insn_word[7:0], 24'd0, insn_word[7:0]} >> rot_amt;
   assign rot_imm  = rot_pair[31:0] | rot_pair[63:32];

   assign br_offset = {{6{insn_word[23]}}, insn_word[23:0], 2'b00};

   // Shifter operand: odd types are register shifts with no amount
   assign sh_type  = insn_word[6:4];
   assign sh_field = insn_word[11:7];
   always_comb begin
      sh_kind = {1'b0, sh_type};
      sh_amt  = 6'd0;
      if (!sh_type[0]) begin
         if (sh_kind == SHK_ROR_IMM && sh_field == 5'd0) begin
            sh_kind = SHK_RRX;
         end else if ((sh_kind == SHK_LSR_IMM || sh_kind == SHK_ASR_IMM) &&
                      sh_field == 5'd0) begin
            sh_amt = 6'd32;
         end else begin
            sh_amt = {1'b0, sh_field};
         end
      end
   end

   always_comb begin
      result               = '0;
      result.recognized    = 1'b1;
      result.cond_code     = insn_word[31:28];
      result.reg_dest      = insn_word[15:12];
      result.reg_base      = insn_word[19:16];
      result.reg_second    = insn_word[3:0];
      result.reg_shift     = insn_word[11:8];
      result.flag_bits     = insn_word[25:20];

      if ((insn_word & BX_MASK) == BX_MATCH) begin
         result.insn_class = CLS_BX;
      end else if ((insn_word & SWP_MASK) == SWP_MATCH) begin
         result.insn_class = CLS_SWP;
      end else if ((insn_word & MUL_MASK) == MUL_MATCH) begin
         result.insn_class = CLS_MUL;
         result.reg_dest   = insn_word[19:16];
         result.reg_base   = insn_word[15:12];
      end else if ((insn_word & MULL_MASK) == MULL_MATCH) begin
         result.insn_class = CLS_MULL;
      end else if ((insn_word & CP_MASK) == CDP_MATCH) begin
         result.insn_class = CLS_CDP;
         result.opcode     = insn_word[23:20];
      end else if ((insn_word & CP_MASK) == MRC_MATCH) begin
         result.insn_class = CLS_MRC_MCR;
         result.opcode     = {1'b0, insn_word[23:21]};
      end else if ((insn_word & SWI_MASK) == SWI_MATCH) begin
         result.insn_class    = CLS_SWI;
         result.operand_value = {8'd0, insn_word[23:0]};
      end else if ((insn_word & HALF_MASK) == HALF_MATCH) begin
         result.insn_class = CLS_HALF;
         result.opcode     = {2'b00, insn_word[6:5]};
         if (insn_word[22]) begin
            result.operand_value = {24'd0, insn_word[11:8], insn_word[3:0]};
         end
      end else if ((insn_word & TOP3_MASK) == BLK_MATCH) begin
         result.insn_class    = CLS_BLOCK;
         result.operand_value = {16'd0, insn_word[15:0]};
      end else if ((insn_word & TOP3_MASK) == BR_MATCH) begin
         result.insn_class    = CLS_BRANCH;
         result.operand_value = fetch_address + 32'd8 + br_offset;
      end else if ((insn_word & TOP3_MASK) == LDC_MATCH) begin
         result.insn_class    = CLS_LDC_STC;
         result.operand_value = {24'd0, insn_word[7:0]};
      end else if ((insn_word & DP_MASK) == DP_MATCH) begin
         if (insn_word == NOP_WORD) begin
            result.insn_class = CLS_NOP;
         end else if ((insn_word & MRS_MASK) == MRS_MATCH) begin
            result.insn_class = CLS_MRS;
         end else if ((insn_word & MSR_MASK) == MSR_MATCH) begin
            result.insn_class = CLS_MSR;
            result.opcode     = insn_word[19:16];
            if (insn_word[19:16] != MSR_FM_CF && insn_word[19:16] != MSR_FM_F &&
                insn_word[19:16] != MSR_FM_C) begin
               result.recognized = 1'b0;
            end
            if (insn_word[25]) begin
               result.operand_value = rot_imm;
            end else if (insn_word[11:4] != 8'd0) begin
               result.recognized = 1'b0;
            end
         end else if (!insn_word[25]) begin
            result.insn_class   = CLS_DATAPROC;
            result.opcode       = insn_word[24:21];
            result.shift_kind   = sh_kind;
            result.shift_amount = sh_amt;
         end else if ((insn_word & MOVW_MASK) == MOVW_MATCH) begin
            result.insn_class    = CLS_MOVW;
            result.operand_value = {16'd0, insn_word[19:16], insn_word[11:0]};
         end else begin
            result.insn_class    = CLS_DATAPROC;
            result.opcode        = insn_word[24:21];
            result.operand_value = rot_imm;
         end
      end else begin
         result.insn_class = CLS_LDR_STR;
         if (insn_word[25]) begin
            result.shift_kind   = sh_kind;
            result.shift_amount = sh_amt;
         end else begin
            result.operand_value = {20'd0, insn_word[11:0]};
         end
      end
   end

endmodule
